@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

// Expression holds in every cycle out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
    else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)

`endif

`endif

@@ rtl/mslcg_pkg.sv @@
// ---------------------------------------------------------------------------
// mslcg_pkg
// Types and constants of the multi-stream combined LCG.
// ---------------------------------------------------------------------------
package mslcg_pkg;

  localparam int NUM_STREAMS_DEF = 32;

  localparam int STREAM_W = 5;
  localparam int SEED_W   = 31;
  localparam int DRAW_W   = 31;
  localparam int FRAC_W   = 32;

  // Operation codes
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_SEED = 1'b1;

  // Status codes
  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_BAD_SEED = 1'b1;

  // Moduli are 2^31 - K, so 2^31 folds to K
  localparam logic [SEED_W-1:0] MOD_ONE  = 31'd2147483563;
  localparam logic [SEED_W-1:0] MOD_TWO  = 31'd2147483399;
  localparam logic [7:0]        FOLD_ONE = 8'd85;
  localparam logic [7:0]        FOLD_TWO = 8'd249;

  localparam logic [SEED_W-1:0] MUL_ONE  = 31'd40014;
  localparam logic [SEED_W-1:0] MUL_TWO  = 31'd40692;
  localparam logic [SEED_W-1:0] JUMP_ONE = 31'd2082007225;
  localparam logic [SEED_W-1:0] JUMP_TWO = 31'd784306273;

  // Sequencer step counts
  typedef logic [2:0] step_t;
  localparam step_t DRAW_WB  = 3'd3;  // new seeds ready, write back
  localparam step_t DRAW_OUT = 3'd4;  // fraction ready, present result
  localparam step_t SEED_WB  = 3'd3;  // jumped seeds ready, write entry

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_SEED
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;       // latch draw address, read stream on input index
    logic seed_load;     // load seeds, write entry 0, entry counter to 1
    logic src_cur;       // multiply running seeds by jump constants
    logic wr_draw;       // write stepped seeds back to the draw address
    logic wr_seed;       // write jumped seeds at entry counter, advance
    logic out_draw;      // load draw result
    logic out_seed_ok;   // load accepted reseed result
    logic out_seed_bad;  // load rejected reseed result
    logic set_seeded;    // table content now valid
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic seed_ok;       // input seeds inside their ranges
    logic cnt_last;      // entry counter at the last stream
  } stat_t;

endpackage

@@ rtl/mslcg_ram.sv @@
// ---------------------------------------------------------------------------
// mslcg_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module mslcg_ram #(
  parameter int WIDTH = 62,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/mslcg_dp.sv @@
// ---------------------------------------------------------------------------
// mslcg_dp
// Seed table, modular multiply pipeline and output scaling.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mslcg_dp #(
  parameter int NUM_STREAMS = mslcg_pkg::NUM_STREAMS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mslcg_pkg::cmd_t                    cmd,
  output mslcg_pkg::stat_t                   stat,
  input  logic [mslcg_pkg::STREAM_W-1:0]     in_stream,
  input  logic [mslcg_pkg::SEED_W-1:0]       in_seed_first,
  input  logic [mslcg_pkg::SEED_W-1:0]       in_seed_second,
  input  logic                               out_valid,
  output logic [mslcg_pkg::DRAW_W-1:0]       out_draw_value,
  output logic [mslcg_pkg::FRAC_W-1:0]       out_uniform_fraction,
  output logic                               out_status
);

  localparam int AW  = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int SW  = mslcg_pkg::SEED_W;
  localparam int PW  = 2 * SW;          // raw product
  localparam int TW  = SW + 9;          // after first fold
  localparam int WW  = SW + 8;          // z * 2K
  localparam int IW  = 16;              // stream index reduction width

  localparam logic [7:0] SCALE = 8'(2 * mslcg_pkg::FOLD_ONE);

  // p mod (2^31 - k), first fold: hi * k + lo
  function automatic logic [TW-1:0] fold_hi(input logic [PW-1:0] p,
                                            input logic [7:0] k);
    return TW'(p[SW-1:0]) + TW'(p[PW-1:SW]) * TW'(k);
  endfunction

  // second fold and final correction, result below the modulus
  function automatic logic [SW-1:0] fold_lo(input logic [TW-1:0] t,
                                            input logic [7:0] k,
                                            input logic [SW-1:0] m);
    logic [SW:0] u;
    u = (SW+1)'(t[SW-1:0]) + (SW+1)'(t[TW-1:SW]) * (SW+1)'(k);
    if (u >= (SW+1)'(m)) begin
      u = u - (SW+1)'(m);
    end
    return u[SW-1:0];
  endfunction

  logic [IW-1:0]     rem_c;
  logic [AW-1:0]     idx_c;
  logic [AW-1:0]     addr_r;
  logic [AW-1:0]     cnt_r;
  logic              seeded_r;

  logic [SW-1:0]     cur1_r, cur2_r;
  logic [SW-1:0]     opd1_c, opd2_c;
  logic [SW-1:0]     mul1_c, mul2_c;
  logic [PW-1:0]     p1_r, p2_r;
  logic [TW-1:0]     t1_r, t2_r;
  logic [SW-1:0]     r1_r, r2_r;

  logic [SW:0]       diff_c;
  logic [SW-1:0]     z_c;
  logic [SW-1:0]     z_r;
  logic [WW-1:0]     w_r;
  logic [7:0]        wh_c;
  logic [SW:0]       v_c;
  logic [SW:0]       frac_c;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [PW-1:0]     ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [PW-1:0]     ram_rdata;

  logic [mslcg_pkg::DRAW_W-1:0] out_draw_value_r;
  logic [mslcg_pkg::FRAC_W-1:0] out_uniform_fraction_r;
  logic                         out_status_r;

  // stream index modulo table depth, restoring remainder over 5 bits
  always_comb begin
    rem_c = IW'(in_stream);
    for (int k = mslcg_pkg::STREAM_W - 1; k >= 0; k--) begin
      if (rem_c >= (IW'(NUM_STREAMS) << k)) begin
        rem_c = rem_c - (IW'(NUM_STREAMS) << k);
      end
    end
    idx_c = AW'(rem_c);
  end

  assign stat.seed_ok  = (in_seed_first  != '0) && (in_seed_first  < mslcg_pkg::MOD_ONE) &&
                         (in_seed_second != '0) && (in_seed_second < mslcg_pkg::MOD_TWO);
  assign stat.cnt_last = (cnt_r == AW'(NUM_STREAMS - 1));

  // seed table: {first, second} per stream
  assign ram_raddr = cmd.capture ? idx_c : addr_r;
  assign ram_we    = cmd.seed_load | cmd.wr_draw | cmd.wr_seed;
  assign ram_waddr = cmd.seed_load ? '0 : (cmd.wr_draw ? addr_r : cnt_r);
  assign ram_wdata = cmd.seed_load ? {in_seed_first, in_seed_second} : {r1_r, r2_r};

  mslcg_ram #(
    .WIDTH (PW),
    .DEPTH (NUM_STREAMS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // table reads as zero until the first accepted reseed fills all entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r <= 1'b0;
    end else if (cmd.set_seeded) begin
      seeded_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_r <= idx_c;
    end
    if (cmd.seed_load) begin
      cur1_r <= in_seed_first;
      cur2_r <= in_seed_second;
      cnt_r  <= AW'(1);
    end else if (cmd.wr_seed) begin
      cur1_r <= r1_r;
      cur2_r <= r2_r;
      cnt_r  <= cnt_r + AW'(1);
    end
  end

  // operand and multiplier select
  always_comb begin
    if (cmd.src_cur) begin
      opd1_c = cur1_r;
      opd2_c = cur2_r;
      mul1_c = mslcg_pkg::JUMP_ONE;
      mul2_c = mslcg_pkg::JUMP_TWO;
    end else begin
      opd1_c = seeded_r ? ram_rdata[PW-1:SW] : '0;
      opd2_c = seeded_r ? ram_rdata[SW-1:0]  : '0;
      mul1_c = mslcg_pkg::MUL_ONE;
      mul2_c = mslcg_pkg::MUL_TWO;
    end
  end

  // modular multiply: product, fold, fold and correct
  always_ff @(posedge clk) begin
    p1_r <= PW'(opd1_c) * PW'(mul1_c);
    p2_r <= PW'(opd2_c) * PW'(mul2_c);
    t1_r <= fold_hi(p1_r, mslcg_pkg::FOLD_ONE);
    t2_r <= fold_hi(p2_r, mslcg_pkg::FOLD_TWO);
    r1_r <= fold_lo(t1_r, mslcg_pkg::FOLD_ONE, mslcg_pkg::MOD_ONE);
    r2_r <= fold_lo(t2_r, mslcg_pkg::FOLD_TWO, mslcg_pkg::MOD_TWO);
  end

  // combined value, wrapped into 1..m1-1
  always_comb begin
    diff_c = {1'b0, r1_r} - {1'b0, r2_r};
    if (diff_c[SW] || (diff_c == '0)) begin
      z_c = SW'(diff_c + (SW+1)'(mslcg_pkg::MOD_ONE - 31'd1));
    end else begin
      z_c = diff_c[SW-1:0];
    end
  end

  // z*2^32/m1 = 2z + floor(2Kz/m1); the second term folds once more
  always_ff @(posedge clk) begin
    z_r <= z_c;
    w_r <= WW'(z_c) * WW'(SCALE);
  end

  always_comb begin
    wh_c   = w_r[WW-1:SW];
    v_c    = (SW+1)'(w_r[SW-1:0]) + (SW+1)'(wh_c) * (SW+1)'(mslcg_pkg::FOLD_ONE);
    frac_c = {z_r, 1'b0} + (SW+1)'(wh_c) + (SW+1)'(v_c >= (SW+1)'(mslcg_pkg::MOD_ONE));
  end

  always_ff @(posedge clk) begin
    if (cmd.out_draw) begin
      out_draw_value_r       <= z_r;
      out_uniform_fraction_r <= frac_c;
      out_status_r           <= mslcg_pkg::STAT_OK;
    end else if (cmd.out_seed_ok || cmd.out_seed_bad) begin
      out_draw_value_r       <= '0;
      out_uniform_fraction_r <= '0;
      out_status_r           <= cmd.out_seed_bad ? mslcg_pkg::STAT_BAD_SEED
                                                 : mslcg_pkg::STAT_OK;
    end
  end

  assign out_draw_value       = out_draw_value_r;
  assign out_uniform_fraction = out_uniform_fraction_r;
  assign out_status           = out_status_r;

  `ASSERT_IMPLY(a_bad_seed_zero, clk, rst_n,
    out_valid && (out_status_r == mslcg_pkg::STAT_BAD_SEED),
    (out_draw_value_r == '0) && (out_uniform_fraction_r == '0),
    "rejected reseed must report zero value and fraction")

endmodule

@@ rtl/mslcg_ctrl.sv @@
// ---------------------------------------------------------------------------
// mslcg_ctrl
// Sequencer for draw and reseed transactions.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mslcg_ctrl #(
  parameter int NUM_STREAMS = mslcg_pkg::NUM_STREAMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_operation,
  input  mslcg_pkg::stat_t  stat,
  output mslcg_pkg::cmd_t   cmd,
  output logic              busy,
  output logic              out_valid
);

  localparam bit SINGLE = (NUM_STREAMS == 1);

  mslcg_pkg::state_t state_r, state_nxt;
  mslcg_pkg::step_t  step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mslcg_pkg::ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      mslcg_pkg::ST_IDLE: begin
        step_nxt = '0;
        if (start) begin
          if (in_operation == mslcg_pkg::OP_DRAW) begin
            cmd.capture = 1'b1;
            state_nxt   = mslcg_pkg::ST_DRAW;
          end else if (stat.seed_ok) begin
            cmd.seed_load = 1'b1;
            if (SINGLE) begin
              cmd.out_seed_ok = 1'b1;
              cmd.set_seeded  = 1'b1;
            end else begin
              state_nxt = mslcg_pkg::ST_SEED;
            end
          end else begin
            cmd.out_seed_bad = 1'b1;
          end
        end
      end
      mslcg_pkg::ST_DRAW: begin
        step_nxt = step_r + 3'd1;
        if (step_r == mslcg_pkg::DRAW_WB) begin
          cmd.wr_draw = 1'b1;
        end
        if (step_r == mslcg_pkg::DRAW_OUT) begin
          cmd.out_draw = 1'b1;
          state_nxt    = mslcg_pkg::ST_IDLE;
        end
      end
      mslcg_pkg::ST_SEED: begin
        cmd.src_cur = 1'b1;
        step_nxt    = step_r + 3'd1;
        if (step_r == mslcg_pkg::SEED_WB) begin
          cmd.wr_seed = 1'b1;
          step_nxt    = '0;
          if (stat.cnt_last) begin
            cmd.out_seed_ok = 1'b1;
            cmd.set_seeded  = 1'b1;
            state_nxt       = mslcg_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = mslcg_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_draw | cmd.out_seed_ok | cmd.out_seed_bad;
  assign busy          = (state_r != mslcg_pkg::ST_IDLE);
  assign out_valid     = out_valid_r;

  `ASSERT_NEXT(a_draw_enters, clk, rst_n,
    start && !busy && (in_operation == mslcg_pkg::OP_DRAW),
    (state_r == mslcg_pkg::ST_DRAW) && (step_r == '0),
    "accepted draw must start the draw sequence at step zero")

  `ASSERT_ALWAYS(a_one_writer, clk, rst_n,
    $onehot0({cmd.seed_load, cmd.wr_draw, cmd.wr_seed}),
    "at most one table write per cycle")

  `ASSERT_ALWAYS(a_one_result, clk, rst_n,
    $onehot0({cmd.out_draw, cmd.out_seed_ok, cmd.out_seed_bad}),
    "at most one result load per cycle")

  `ASSERT_IMPLY(a_seed_step, clk, rst_n,
    state_r == mslcg_pkg::ST_SEED,
    step_r <= mslcg_pkg::SEED_WB,
    "reseed step counter out of range")

  `ASSERT_NEXT(a_result_frees, clk, rst_n,
    out_valid_nxt,
    !busy,
    "block must be free while a result is shown")

endmodule

@@ rtl/multi_stream_combined_lcg.sv @@
// ---------------------------------------------------------------------------
// multi_stream_combined_lcg
// NUM_STREAMS independent streams of a two-component combined LCG.
// ---------------------------------------------------------------------------
// Usage:
//   Input transaction: taken on a clock edge with start high and busy low.
//   in_operation selects a draw (step stream in_stream, reduced modulo
//   NUM_STREAMS) or a reseed (stream 0 gets the two seeds, each further
//   stream the previous one jumped ahead by 2^30 steps per component).
//   Result transaction: out_valid is high for exactly one cycle with
//   out_draw_value, out_uniform_fraction and out_status; the receiver
//   cannot stall, so it must take the result in that cycle.
//   Draw: the result passes the registered table read, the three-stage
//   modular multiply (product and two folds) and the two-stage fraction
//   scaling; busy stays high until the result shows, so a new draw is not
//   taken while one is in flight.
//   Reseed: streams after stream 0 pass one by one through the same
//   multiply, busy high until the last is written (never with one stream).
//   A reseed with a seed out of range changes nothing and returns status 1
//   in the cycle after acceptance.
//   Reset: synchronous, active low. All streams read as zero afterwards
//   until the first accepted reseed; no clearing pass is needed.
// ---------------------------------------------------------------------------
module multi_stream_combined_lcg #(
  parameter int NUM_STREAMS = mslcg_pkg::NUM_STREAMS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input transaction
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_operation,
  input  logic [mslcg_pkg::STREAM_W-1:0] in_stream,
  input  logic [mslcg_pkg::SEED_W-1:0]   in_seed_first,
  input  logic [mslcg_pkg::SEED_W-1:0]   in_seed_second,
  // result transaction
  output logic                           out_valid,
  output logic [mslcg_pkg::DRAW_W-1:0]   out_draw_value,
  output logic [mslcg_pkg::FRAC_W-1:0]   out_uniform_fraction,
  output logic                           out_status
);

  // command and status between sequencer and datapath
  mslcg_pkg::cmd_t  cmd;
  mslcg_pkg::stat_t stat;

  // sequencer: idle / draw / reseed walk, owns busy and the result strobe
  mslcg_ctrl #(
    .NUM_STREAMS (NUM_STREAMS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy),
    .out_valid    (out_valid)
  );

  // datapath: seed table RAM, modular multiply pipeline, output registers
  mslcg_dp #(
    .NUM_STREAMS (NUM_STREAMS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_stream            (in_stream),
    .in_seed_first        (in_seed_first),
    .in_seed_second       (in_seed_second),
    .out_valid            (out_valid),
    .out_draw_value       (out_draw_value),
    .out_uniform_fraction (out_uniform_fraction),
    .out_status           (out_status)
  );

endmodule

@@ dv/tb_multi_stream_combined_lcg.sv @@
// ---------------------------------------------------------------------------
// tb_multi_stream_combined_lcg
// Self-checking bench for the 32-stream combined LCG. The bench first runs a
// short table of directed transactions. These cover unseeded draws, seeds at
// and just past both range limits, and draws after reseeds. Then it runs
// about 1100 random transactions, mostly draws with occasional good or bad
// reseeds. A local mirror of both seed tables predicts every result.
// ---------------------------------------------------------------------------
module tb_multi_stream_combined_lcg;

  typedef longint unsigned u64_t;

  // Package constants used throughout the bench
  localparam int STREAM_W = mslcg_pkg::STREAM_W;
  localparam int SEED_W   = mslcg_pkg::SEED_W;
  localparam int DRAW_W   = mslcg_pkg::DRAW_W;
  localparam int FRAC_W   = mslcg_pkg::FRAC_W;

  localparam logic OP_DRAW       = mslcg_pkg::OP_DRAW;
  localparam logic OP_SEED       = mslcg_pkg::OP_SEED;
  localparam logic STAT_OK       = mslcg_pkg::STAT_OK;
  localparam logic STAT_BAD_SEED = mslcg_pkg::STAT_BAD_SEED;

  localparam logic [SEED_W-1:0] MOD_ONE  = mslcg_pkg::MOD_ONE;
  localparam logic [SEED_W-1:0] MOD_TWO  = mslcg_pkg::MOD_TWO;
  localparam logic [SEED_W-1:0] MUL_ONE  = mslcg_pkg::MUL_ONE;
  localparam logic [SEED_W-1:0] MUL_TWO  = mslcg_pkg::MUL_TWO;
  localparam logic [SEED_W-1:0] JUMP_ONE = mslcg_pkg::JUMP_ONE;
  localparam logic [SEED_W-1:0] JUMP_TWO = mslcg_pkg::JUMP_TWO;

  localparam int   NUM_STREAMS  = mslcg_pkg::NUM_STREAMS_DEF;
  localparam int   RANDOM_ITEMS = 1130;
  localparam int   PHASE_LEN    = 50;     // transactions per idle phase
  localparam int   DRAIN_CYCLES = 20;     // well past the draw latency
  localparam int   CYCLE_LIMIT  = 1000000;
  localparam u64_t M1           = MOD_ONE;
  localparam u64_t M2           = MOD_TWO;

  localparam logic [SEED_W-1:0] SEED1_MAX = 31'd2147483562;
  localparam logic [SEED_W-1:0] SEED2_MAX = 31'd2147483398;
  localparam logic [SEED_W-1:0] ONES31    = 31'h7fffffff;
  // Zero seeds stay zero, so z wraps to m1-1; floor((m1-1) * 2^32 / m1)
  localparam logic [DRAW_W-1:0] ZERO_SEED_DRAW = 31'd2147483562;
  localparam logic [FRAC_W-1:0] ZERO_SEED_FRAC = 32'd4294967293;

  typedef struct packed {
    logic                op;
    logic [STREAM_W-1:0] stream;
    logic [SEED_W-1:0]   s1;
    logic [SEED_W-1:0]   s2;
  } lcg_item_t;

  typedef struct packed {
    logic [DRAW_W-1:0] draw;
    logic [FRAC_W-1:0] frac;
    logic              status;
  } lcg_result_t;

  // Directed row: transaction, plus a hand-written result where one is obvious
  typedef struct packed {
    logic                op;
    logic [STREAM_W-1:0] stream;
    logic [SEED_W-1:0]   s1;
    logic [SEED_W-1:0]   s2;
    logic                known;
    logic [DRAW_W-1:0]   draw;
    logic [FRAC_W-1:0]   frac;
    logic                status;
  } dir_row_t;

  localparam int DIR_ROWS = 23;

  dir_row_t dir_table [DIR_ROWS] = '{
    // draws from a fresh (all-zero) table
    '{OP_DRAW, 5'd0,  31'd0,      31'd0,      1'b1, ZERO_SEED_DRAW, ZERO_SEED_FRAC, STAT_OK},
    '{OP_DRAW, 5'd31, ONES31,     ONES31,     1'b1, ZERO_SEED_DRAW, ZERO_SEED_FRAC, STAT_OK},
    // seeds just outside the legal ranges are rejected
    '{OP_SEED, 5'd0,  31'd0,      31'd1,      1'b1, 31'd0, 32'd0, STAT_BAD_SEED},
    '{OP_SEED, 5'd3,  MOD_ONE,    31'd1,      1'b1, 31'd0, 32'd0, STAT_BAD_SEED},
    '{OP_SEED, 5'd31, ONES31,     ONES31,     1'b1, 31'd0, 32'd0, STAT_BAD_SEED},
    '{OP_SEED, 5'd0,  31'd1,      31'd0,      1'b1, 31'd0, 32'd0, STAT_BAD_SEED},
    '{OP_SEED, 5'd0,  31'd1,      MOD_TWO,    1'b1, 31'd0, 32'd0, STAT_BAD_SEED},
    '{OP_SEED, 5'd0,  SEED1_MAX,  ONES31,     1'b1, 31'd0, 32'd0, STAT_BAD_SEED},
    // rejected reseeds left the table untouched
    '{OP_DRAW, 5'd17, 31'd0,      31'd0,      1'b1, ZERO_SEED_DRAW, ZERO_SEED_FRAC, STAT_OK},
    // smallest legal seeds
    '{OP_SEED, 5'd0,  31'd1,      31'd1,      1'b1, 31'd0, 32'd0, STAT_OK},
    '{OP_DRAW, 5'd0,  31'd0,      31'd0,      1'b0, 31'd0, 32'd0, STAT_OK},
    '{OP_DRAW, 5'd31, 31'd0,      31'd0,      1'b0, 31'd0, 32'd0, STAT_OK},
    '{OP_DRAW, 5'd0,  31'd0,      31'd0,      1'b0, 31'd0, 32'd0, STAT_OK},
    // largest legal seeds
    '{OP_SEED, 5'd31, SEED1_MAX,  SEED2_MAX,  1'b1, 31'd0, 32'd0, STAT_OK},
    '{OP_DRAW, 5'd0,  31'd0,      31'd0,      1'b0, 31'd0, 32'd0, STAT_OK},
    '{OP_DRAW, 5'd1,  31'd0,      31'd0,      1'b0, 31'd0, 32'd0, STAT_OK},
    '{OP_DRAW, 5'd16, 31'd0,      31'd0,      1'b0, 31'd0, 32'd0, STAT_OK},
    '{OP_DRAW, 5'd31, ONES31,     ONES31,     1'b0, 31'd0, 32'd0, STAT_OK},
    // alternating bit patterns
    '{OP_SEED, 5'd5,  31'h2aaaaaaa, 31'h55555555, 1'b1, 31'd0, 32'd0, STAT_OK},
    '{OP_DRAW, 5'd10, 31'd0,      31'd0,      1'b0, 31'd0, 32'd0, STAT_OK},
    '{OP_DRAW, 5'd10, 31'd0,      31'd0,      1'b0, 31'd0, 32'd0, STAT_OK},
    // mixed extremes
    '{OP_SEED, 5'd0,  31'd1,      SEED2_MAX,  1'b1, 31'd0, 32'd0, STAT_OK},
    '{OP_DRAW, 5'd31, 31'd0,      31'd0,      1'b0, 31'd0, 32'd0, STAT_OK}
  };

  // Sender idle percentage per phase: none, heavy, light
  int idle_pct_by_phase [3] = '{0, 58, 8};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic                in_operation = OP_DRAW;
  logic [STREAM_W-1:0] in_stream = '0;
  logic [SEED_W-1:0]   in_seed_first = '0;
  logic [SEED_W-1:0]   in_seed_second = '0;
  logic                out_valid;
  logic [DRAW_W-1:0]   out_draw_value;
  logic [FRAC_W-1:0]   out_uniform_fraction;
  logic                out_status;

  // Mirror of the two seed tables, both zero out of reset
  logic [SEED_W-1:0] seed_one_mirror [NUM_STREAMS];
  logic [SEED_W-1:0] seed_two_mirror [NUM_STREAMS];

  lcg_result_t draw_queue [$];  // results owed by the block, oldest first
  int idle_pct = 0;
  int error_count = 0;
  int cycle_count = 0;

  multi_stream_combined_lcg #(
    .NUM_STREAMS(NUM_STREAMS)
  ) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_stream           (in_stream),
    .in_seed_first       (in_seed_first),
    .in_seed_second      (in_seed_second),
    .out_valid           (out_valid),
    .out_draw_value      (out_draw_value),
    .out_uniform_fraction(out_uniform_fraction),
    .out_status          (out_status)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic logic [SEED_W-1:0] mulmod(input logic [SEED_W-1:0] a,
                                               input logic [SEED_W-1:0] s,
                                               input u64_t m);
    u64_t prod;
    prod = u64_t'(a) * u64_t'(s);
    return SEED_W'(prod % m);
  endfunction

  // Steps the mirror for one transaction and returns the result it owes
  function automatic lcg_result_t compute_draw(input lcg_item_t it);
    lcg_result_t r;
    logic [STREAM_W-1:0] idx;
    longint z;
    u64_t zu;
    r = '0;
    if (it.op == OP_DRAW) begin
      idx = it.stream;  // 5-bit index covers all 32 streams, modulo is a no-op
      seed_one_mirror[idx] = mulmod(MUL_ONE, seed_one_mirror[idx], M1);
      seed_two_mirror[idx] = mulmod(MUL_TWO, seed_two_mirror[idx], M2);
      z = longint'(seed_one_mirror[idx]) - longint'(seed_two_mirror[idx]);
      if (z < 1) z = z + longint'(M1) - 1;
      zu = u64_t'(z);
      r.draw = zu[DRAW_W-1:0];
      r.frac = FRAC_W'((zu << 32) / M1);
      r.status = STAT_OK;
    end else if (it.s1 >= 31'd1 && it.s1 < MOD_ONE && it.s2 >= 31'd1 && it.s2 < MOD_TWO) begin
      seed_one_mirror[0] = it.s1;
      seed_two_mirror[0] = it.s2;
      // each stream sits 2^30 steps ahead of the previous one
      for (int g = 1; g < NUM_STREAMS; g++) begin
        seed_one_mirror[g] = mulmod(JUMP_ONE, seed_one_mirror[g-1], M1);
        seed_two_mirror[g] = mulmod(JUMP_TWO, seed_two_mirror[g-1], M2);
      end
      r.status = STAT_OK;
    end else begin
      r.status = STAT_BAD_SEED;
    end
    return r;
  endfunction

  // Mostly draws; reseeds now and then, a quarter of them out of range
  function automatic lcg_item_t random_item();
    lcg_item_t it;
    it.stream = STREAM_W'($urandom);
    it.s1 = SEED_W'($urandom);
    it.s2 = SEED_W'($urandom);
    if ($urandom_range(99) < 90) begin
      it.op = OP_DRAW;
    end else begin
      it.op = OP_SEED;
      it.s1 = SEED_W'($urandom_range(1, SEED1_MAX));
      it.s2 = SEED_W'($urandom_range(1, SEED2_MAX));
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(3))
          0: it.s1 = '0;
          1: it.s1 = SEED_W'($urandom_range(MOD_ONE, ONES31));
          2: it.s2 = '0;
          default: it.s2 = SEED_W'($urandom_range(MOD_TWO, ONES31));
        endcase
      end
    end
    return it;
  endfunction

  // Called just after a rising edge. start is left high after acceptance so
  // back-to-back transactions never lower and raise it in the same step.
  task automatic send_item(input lcg_item_t it, input logic known,
                           input lcg_result_t typed);
    lcg_result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_operation   <= it.op;
    in_stream      <= it.stream;
    in_seed_first  <= it.s1;
    in_seed_second <= it.s2;
    do @(posedge clk); while (busy);
    // transaction accepted at this edge
    predicted = compute_draw(it);
    draw_queue.push_back(known ? typed : predicted);
  endtask

  // Result checker: the block cannot be stalled, so every strobe is taken
  always @(posedge clk) begin : result_check
    lcg_result_t want;
    if (rst_n && out_valid) begin
      if (draw_queue.size() == 0) begin
        report_mismatch("result with no transaction pending");
      end else begin
        want = draw_queue.pop_front();
        if (out_draw_value !== want.draw)
          report_mismatch($sformatf("draw_value got %0d want %0d",
                                    out_draw_value, want.draw));
        if (out_uniform_fraction !== want.frac)
          report_mismatch($sformatf("uniform_fraction got %0d want %0d",
                                    out_uniform_fraction, want.frac));
        if (out_status !== want.status)
          report_mismatch($sformatf("status got %0b want %0b",
                                    out_status, want.status));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    lcg_item_t   it;
    lcg_result_t typed;
    for (int g = 0; g < NUM_STREAMS; g++) begin
      seed_one_mirror[g] = '0;
      seed_two_mirror[g] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, sender never idle
    foreach (dir_table[i]) begin
      it    = '{dir_table[i].op, dir_table[i].stream, dir_table[i].s1, dir_table[i].s2};
      typed = '{dir_table[i].draw, dir_table[i].frac, dir_table[i].status};
      send_item(it, dir_table[i].known, typed);
    end

    // Random part, idle rate changes every PHASE_LEN transactions
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_pct = idle_pct_by_phase[(i / PHASE_LEN) % 3];
      send_item(random_item(), 1'b0, '0);
    end
    start <= 1'b0;

    while (draw_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (draw_queue.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", draw_queue.size()));

    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
